/* design/assert_macros.svh */
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every cycle outside reset.
`define BTFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BTFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/btfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btfp_pkg;

  typedef logic [7:0]         byte_t;
  typedef logic [3:0]         kind_t;
  typedef logic [6:0]         cell_t;
  typedef logic signed [32:0] value_t;

  localparam int unsigned HEADER_BYTES_DEF = 11;

  localparam kind_t KIND_CELL    = 4'd0;
  localparam kind_t KIND_TEMP1   = 4'd1;
  localparam kind_t KIND_TEMP2   = 4'd2;
  localparam kind_t KIND_TEMP3   = 4'd3;
  localparam kind_t KIND_PACK    = 4'd4;
  localparam kind_t KIND_CURRENT = 4'd5;
  localparam kind_t KIND_SOC     = 4'd6;
  localparam kind_t KIND_CYCLES  = 4'd7;
  localparam kind_t KIND_CAP     = 4'd8;
  localparam kind_t KIND_WARN    = 4'd9;
  localparam kind_t KIND_STATUS  = 4'd10;
  localparam kind_t KIND_ERROR   = 4'd11;
  localparam kind_t KIND_NONE    = 4'd15;

  localparam logic [3:0] FIELD_LAST = 4'd12;

  // Expected tag byte of each field, in frame order.
  function automatic byte_t field_tag(input logic [3:0] idx);
    byte_t t;
    unique case (idx)
      4'd0:    t = 8'h79;
      4'd1:    t = 8'h80;
      4'd2:    t = 8'h81;
      4'd3:    t = 8'h82;
      4'd4:    t = 8'h83;
      4'd5:    t = 8'h84;
      4'd6:    t = 8'h85;
      4'd7:    t = 8'h86;
      4'd8:    t = 8'h87;
      4'd9:    t = 8'h89;
      4'd10:   t = 8'h8a;
      4'd11:   t = 8'h8b;
      4'd12:   t = 8'h8c;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

  // Value bytes after the tag.
  function automatic logic [2:0] field_len(input logic [3:0] idx);
    logic [2:0] n;
    unique case (idx)
      4'd0, 4'd6, 4'd7: n = 3'd1;
      4'd9:             n = 3'd4;
      default:          n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic kind_t field_kind_of(input logic [3:0] idx);
    kind_t k;
    unique case (idx)
      4'd0:    k = KIND_CELL;
      4'd1:    k = KIND_TEMP1;
      4'd2:    k = KIND_TEMP2;
      4'd3:    k = KIND_TEMP3;
      4'd4:    k = KIND_PACK;
      4'd5:    k = KIND_CURRENT;
      4'd6:    k = KIND_SOC;
      4'd8:    k = KIND_CYCLES;
      4'd9:    k = KIND_CAP;
      4'd11:   k = KIND_WARN;
      4'd12:   k = KIND_STATUS;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/btfp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface btfp_in_if;
  logic             valid;
  logic             ready;
  btfp_pkg::byte_t  frame_byte;
  logic             frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface btfp_out_if;
  logic             valid;
  logic             ready;
  btfp_pkg::kind_t  field_kind;
  btfp_pkg::cell_t  cell_number;
  btfp_pkg::value_t field_value;
  logic             frame_done;

  modport source (output valid, output field_kind, output cell_number,
                  output field_value, output frame_done, input ready);
  modport sink   (input valid, input field_kind, input cell_number,
                  input field_value, input frame_done, output ready);
endinterface

`default_nettype wire

/* design/battery_telemetry_frame_parser_top.sv */
// Channel    | Dir | Payload                                            | Handshake
// in_chan    | in  | frame_byte[7:0], frame_start                       | valid/ready
// out_chan   | out | field_kind[3:0], cell_number[6:0], field_value[32:0], frame_done
//            |     |                                                    | valid/ready
// One byte is taken every cycle while no stalled result holds the flow; each byte goes
// into the input register and its result, if any, into the result register. The rate
// is set by the single parse step between the two. Synchronous active-low reset returns
// the parser to idle with no item held. A stalled result holds the result register; the
// input register then holds one more byte before in_chan.ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module battery_telemetry_frame_parser_top #(
  parameter int unsigned HEADER_BYTES = btfp_pkg::HEADER_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  btfp_in_if.sink        in_chan,
  btfp_out_if.source     out_chan
);
  import btfp_pkg::*;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_HEADER = 5'd1;
  localparam logic [4:0] PH_TAG0   = 5'd2;
  localparam logic [4:0] PH_TAG1   = 5'd4;
  localparam logic [4:0] PH_LAST   = 5'd27;
  localparam logic [4:0] PH_CELLS  = 5'd28;

  localparam logic [3:0] HDR_LEN     = 4'(HEADER_BYTES);
  localparam logic [4:0] START_PHASE = (HEADER_BYTES > 0) ? PH_HEADER : PH_TAG0;

  // Input register
  logic        s1_valid_r;
  byte_t       s1_byte_r;
  logic        s1_start_r;
  logic        s1_adv;

  // Parse state
  logic [4:0]  phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [6:0]  cl_r, cl_nxt;
  logic [6:0]  cc_r, cc_nxt;
  logic [31:0] vg_r, vg_nxt;

  // Result register
  logic        out_valid_r;
  kind_t       out_kind_r;
  cell_t       out_cell_r;
  value_t      out_value_r;
  logic        out_done_r;

  // Step logic
  logic [4:0]  ph;
  logic [3:0]  pos;
  logic [6:0]  cl;
  logic [6:0]  cc;
  logic [31:0] vg;
  logic [31:0] vg_shift;
  logic [3:0]  pos_inc;
  logic [6:0]  cl_dec;
  logic [4:0]  ph_off;
  logic [3:0]  fidx;
  logic [15:0] cnt_prod;
  logic [6:0]  cnt_div3;
  logic [15:0] raw16;
  logic [19:0] x10;
  kind_t       fkind;
  logic        emit;
  kind_t       e_kind;
  cell_t       e_cell;
  logic [32:0] e_value;
  logic        e_done;
  logic [32:0] dec_value;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r  <= in_chan.frame_byte;
      s1_start_r <= in_chan.frame_start;
    end
  end

  assign ph       = s1_start_r ? START_PHASE : phase_r;
  assign pos      = s1_start_r ? 4'd0  : pos_r;
  assign cl       = s1_start_r ? 7'd0  : cl_r;
  assign cc       = s1_start_r ? 7'd0  : cc_r;
  assign vg       = s1_start_r ? 32'd0 : vg_r;
  assign vg_shift = {vg[23:0], s1_byte_r};
  assign pos_inc  = pos + 4'd1;
  assign cl_dec   = cl - 7'd1;
  assign ph_off   = ph - PH_TAG0;
  assign fidx     = ph_off[4:1];
  assign fkind    = field_kind_of(fidx);

  // Count byte divided by three: 171/512 is exact for every byte value.
  assign cnt_prod = {8'd0, s1_byte_r} * 16'd171;
  assign cnt_div3 = cnt_prod[15:9];

  assign raw16 = vg_shift[15:0];
  assign x10   = {1'b0, raw16, 3'b000} + {3'b000, raw16, 1'b0};

  always_comb begin
    unique case (fkind)
      KIND_TEMP1, KIND_TEMP2, KIND_TEMP3: begin
        if (raw16 > 16'd100) begin
          dec_value = 33'd100 - {17'd0, raw16};
        end else begin
          dec_value = {17'd0, raw16};
        end
      end
      KIND_PACK: dec_value = {13'd0, x10};
      KIND_CURRENT: begin
        if (raw16[15]) begin
          dec_value = 33'd0 - {13'd0, x10};
        end else begin
          dec_value = {13'd0, x10};
        end
      end
      default: dec_value = {1'b0, vg_shift};
    endcase
  end

  always_comb begin
    phase_nxt = ph;
    pos_nxt   = pos;
    cl_nxt    = cl;
    cc_nxt    = cc;
    vg_nxt    = vg;
    emit      = 1'b0;
    e_kind    = KIND_CELL;
    e_cell    = '0;
    e_value   = '0;
    e_done    = 1'b0;
    priority if (ph == PH_HEADER) begin
      pos_nxt = pos_inc;
      if (pos_inc >= HDR_LEN) begin
        phase_nxt = PH_TAG0;
        pos_nxt   = 4'd0;
      end
    end else if (ph == PH_CELLS) begin
      // Entry: index byte (dropped), then the 16-bit cell voltage.
      if (pos == 4'd0) begin
        pos_nxt = 4'd1;
      end else if (pos == 4'd1) begin
        vg_nxt  = {24'd0, s1_byte_r};
        pos_nxt = 4'd2;
      end else begin
        emit    = 1'b1;
        e_kind  = KIND_CELL;
        e_cell  = cc;
        e_value = {17'd0, vg[7:0], s1_byte_r};
        cc_nxt  = cc + 7'd1;
        cl_nxt  = cl_dec;
        pos_nxt = 4'd0;
        if (cl_dec == 7'd0) begin
          phase_nxt = PH_TAG1;
        end
      end
    end else if (ph < PH_TAG0 || ph > PH_LAST) begin
      phase_nxt = PH_IDLE;
    end else if (!ph[0]) begin
      if (s1_byte_r != field_tag(fidx)) begin
        emit      = 1'b1;
        e_kind    = KIND_ERROR;
        e_value   = {25'd0, field_tag(fidx)};
        e_done    = 1'b1;
        phase_nxt = PH_IDLE;
        pos_nxt   = 4'd0;
      end else begin
        phase_nxt = ph + 5'd1;
        pos_nxt   = 4'd0;
        vg_nxt    = 32'd0;
      end
    end else if (fidx == 4'd0) begin
      cl_nxt    = cnt_div3;
      cc_nxt    = 7'd0;
      pos_nxt   = 4'd0;
      phase_nxt = (cnt_div3 == 7'd0) ? PH_TAG1 : PH_CELLS;
    end else begin
      vg_nxt  = vg_shift;
      pos_nxt = pos_inc;
      if (pos_inc >= {1'b0, field_len(fidx)}) begin
        pos_nxt = 4'd0;
        if (fidx == FIELD_LAST) begin
          phase_nxt = PH_IDLE;
          emit      = 1'b1;
          e_kind    = fkind;
          e_value   = {1'b0, vg_shift};
          e_done    = 1'b1;
        end else begin
          // The next tag phase directly follows this value phase.
          phase_nxt = ph + 5'd1;
          if (fkind != KIND_NONE) begin
            emit    = 1'b1;
            e_kind  = fkind;
            e_value = dec_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= 4'd0;
      cl_r    <= 7'd0;
      cc_r    <= 7'd0;
      vg_r    <= 32'd0;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cl_r    <= cl_nxt;
      cc_r    <= cc_nxt;
      vg_r    <= vg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && emit) begin
      out_kind_r  <= e_kind;
      out_cell_r  <= e_cell;
      out_value_r <= $signed(e_value);
      out_done_r  <= e_done;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.field_kind  = out_kind_r;
  assign out_chan.cell_number = out_cell_r;
  assign out_chan.field_value = out_value_r;
  assign out_chan.frame_done  = out_done_r;

  `BTFP_ASSERT(a_done_kind, !out_valid_r || !out_done_r || out_kind_r == KIND_STATUS || out_kind_r == KIND_ERROR, "frame_done on a non-final field")
  `BTFP_ASSERT(a_cell_zero, !out_valid_r || out_kind_r == KIND_CELL || out_cell_r == 7'd0, "cell_number set on a non-cell field")
  `BTFP_ASSERT_NEXT(a_done_idle, s1_adv && emit && e_done, phase_r == PH_IDLE && out_valid_r, "parser not idle after frame end")
  `BTFP_ASSERT(a_phase_range, phase_r <= PH_CELLS, "parse phase out of range")

endmodule

`default_nettype wire
